// ===== src/nnue_pkg.sv =====
`timescale 1ns / 1ps
package nnue_pkg;
    localparam int HIDDEN_SIZE = 32;
    localparam int ELEM_W = (HIDDEN_SIZE > 1) ? $clog2(HIDDEN_SIZE) : 1;
    localparam int ROWS = 768;
    localparam int ROW_W = 10;
    localparam int WDEPTH = ROWS * HIDDEN_SIZE;
    localparam int WADDR_W = $clog2(WDEPTH);
    localparam int PIECE_KINDS = 6;

    localparam logic [2:0] REQ_WWRITE = 3'd0;
    localparam logic [2:0] REQ_AWRITE = 3'd1;
    localparam logic [2:0] REQ_AREAD = 3'd2;
    localparam logic [2:0] REQ_QUIET = 3'd3;
    localparam logic [2:0] REQ_CAPTURE = 3'd4;
    localparam logic [2:0] REQ_CASTLE = 3'd5;

    localparam logic [5:0] RANK_FLIP = 6'b111000;
    localparam logic [5:0] FILE_FLIP = 6'd7;

    localparam logic [0:0] CFG_MIRROR_WHITE = 1'b0;
    localparam logic [0:0] CFG_MIRROR_BLACK = 1'b1;

    typedef struct packed {
        logic       valid;
        logic [ROW_W-1:0] row;
    } frow_t;

    function automatic frow_t feature_row(input logic persp, input logic side,
                                          input logic [2:0] piece,
                                          input logic [5:0] square,
                                          input logic mirror);
        frow_t r;
        logic s;
        logic [5:0] q;
        s = side ^ persp;
        q = square ^ (persp ? RANK_FLIP : 6'd0) ^ (mirror ? FILE_FLIP : 6'd0);
        r.valid = (piece < 3'(PIECE_KINDS));
        r.row = (s ? ROW_W'(384) : ROW_W'(0)) + {1'b0, piece, q};
        return r;
    endfunction
endpackage

// ===== src/nnue_accumulator_update_top.sv =====
`timescale 1ns / 1ps
// channel | dir | fields (low bit up)
// s_axis  | in  | tdata: req_type, side_to_move, add1_square, add1_piece, add2_square,
//         |     |   add2_piece, sub1_square, sub1_piece, sub2_square, sub2_piece,
//         |     |   element_index, data_value
// m_axis  | out | tdata: read_value
// cfg     | in  | cfg_we, cfg_index, cfg_data (1 bit)
// Updates do 8 weight reads per hidden element (4 rows x 2 perspectives), wait for the
// last read to land, then write back, for each of the HIDDEN_SIZE elements in turn.
// Weight and accumulator memories have no reset; control state resets async.
// One item at a time; result held in the output register until taken.
module nnue_accumulator_update_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // fields as listed above, bits 63:61 zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // read_value
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_data
);
    import nnue_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_ACC  = 5'b00010,
        ST_RUN  = 5'b00100,
        ST_WB   = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg;
    logic mw_reg, mb_reg;
    logic [63:0] item_reg;
    logic [ELEM_W-1:0] elem_reg;
    logic [2:0] step_reg;
    logic step_v_reg;
    logic [15:0] accw_reg, accb_reg, out_reg;
    logic last_reg;

    logic [15:0] wmem [WDEPTH];
    logic [15:0] amem_w [HIDDEN_SIZE];
    logic [15:0] amem_b [HIDDEN_SIZE];
    logic [15:0] wrd_reg, arw_reg, arb_reg;

    logic [2:0] req;
    logic stm;
    logic [4:0] eidx;
    logic [15:0] dval;
    assign req  = item_reg[2:0];
    assign stm  = item_reg[3];
    assign eidx = item_reg[44:40];
    assign dval = item_reg[60:45];
    logic elem_ok;
    assign elem_ok = 32'(eidx) < HIDDEN_SIZE;

    // step: bit2 perspective, bits1:0 term (add1, add2, sub1, sub2)
    frow_t fr;
    logic [2:0] tp;
    logic [5:0] tsq;
    logic tside, tused, persp;
    always_comb
    begin
        persp = step_reg[2];
        tside = stm;
        tused = 1'b1;
        case (step_reg[1:0])
            2'd0: begin tp = item_reg[12:10]; tsq = item_reg[9:4]; end
            2'd1: begin tp = item_reg[21:19]; tsq = item_reg[18:13];
                        tused = (req == REQ_CASTLE); end
            2'd2: begin tp = item_reg[30:28]; tsq = item_reg[27:22]; end
            default: begin tp = item_reg[39:37]; tsq = item_reg[36:31];
                        tused = (req != REQ_QUIET);
                        tside = (req == REQ_CAPTURE) ? ~stm : stm; end
        endcase
        fr = feature_row(persp, tside, tp, tsq, persp ? mb_reg : mw_reg);
        fr.valid = fr.valid & tused;
    end

    logic [WADDR_W-1:0] raddr;
    assign raddr = WADDR_W'(fr.row) * WADDR_W'(HIDDEN_SIZE) + WADDR_W'(elem_reg);

    frow_t wr_fr;
    assign wr_fr = feature_row(1'b0, stm, item_reg[12:10], item_reg[9:4], 1'b0);
    logic [WADDR_W-1:0] waddr;
    assign waddr = WADDR_W'(wr_fr.row) * WADDR_W'(HIDDEN_SIZE) + WADDR_W'(eidx[ELEM_W-1:0]);

    logic wwe;
    assign wwe = (state_reg == ST_ACC) && (req == REQ_WWRITE) && wr_fr.valid && elem_ok;

    always_ff @(posedge clk)
    begin
        if (wwe)
            wmem[waddr] <= dval;
        wrd_reg <= wmem[raddr];
        arw_reg <= amem_w[elem_reg];
        arb_reg <= amem_b[elem_reg];
    end

    logic term_ok_reg;
    logic dv_reg;
    logic [2:0] dstep_reg;

    // accumulate term from the registered read
    logic [15:0] tw;
    assign tw = term_ok_reg ? wrd_reg : 16'd0;

    logic acc_we_w, acc_we_b;
    logic [ELEM_W-1:0] acc_wa;
    logic [15:0] acc_wd_w, acc_wd_b;

    always_comb
    begin
        acc_we_w = 1'b0;
        acc_we_b = 1'b0;
        acc_wa = eidx[ELEM_W-1:0];
        acc_wd_w = dval;
        acc_wd_b = dval;
        if (state_reg == ST_ACC && req == REQ_AWRITE && elem_ok)
        begin
            acc_we_w = ~stm;
            acc_we_b = stm;
        end
        else if (state_reg == ST_WB && !last_reg)
        begin
            acc_we_w = 1'b1;
            acc_we_b = 1'b1;
            acc_wa = elem_reg;
            acc_wd_w = accw_reg;
            acc_wd_b = accb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_we_w)
            amem_w[acc_wa] <= acc_wd_w;
        if (acc_we_b)
            amem_b[acc_wa] <= acc_wd_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mw_reg <= 1'b0;
            mb_reg <= 1'b0;
            step_v_reg <= 1'b0;
            dv_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_MIRROR_WHITE)
                    mw_reg <= cfg_data;
                else
                    mb_reg <= cfg_data;
            end
            dv_reg <= (state_reg == ST_RUN) && step_v_reg;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        item_reg <= s_axis_tdata;
                        elem_reg <= s_axis_tdata[40 +: ELEM_W];
                        state_reg <= ST_ACC;
                    end
                end
                ST_ACC:
                begin
                    out_reg <= 16'd0;
                    if (req == REQ_AREAD)
                    begin
                        elem_reg <= eidx[ELEM_W-1:0];
                        state_reg <= ST_WB;
                        last_reg <= 1'b1;
                    end
                    else if (req == REQ_QUIET || req == REQ_CAPTURE || req == REQ_CASTLE)
                    begin
                        elem_reg <= '0;
                        step_reg <= 3'd0;
                        step_v_reg <= 1'b1;
                        state_reg <= ST_RUN;
                    end
                    else
                        state_reg <= ST_OUT;
                end
                ST_RUN:
                begin
                    // read issued at step, data lands next cycle
                    if (step_v_reg)
                    begin
                        dstep_reg <= step_reg;
                        term_ok_reg <= fr.valid;
                        step_reg <= step_reg + 3'd1;
                        if (step_reg == 3'd7)
                            step_v_reg <= 1'b0;
                    end
                    if (dv_reg)
                    begin
                        // first term of each perspective starts from the accumulator read
                        if (dstep_reg == 3'd0)
                            accw_reg <= arw_reg + tw;
                        else if (dstep_reg == 3'd4)
                            accb_reg <= arb_reg + tw;
                        else if (dstep_reg[2])
                            accb_reg <= (dstep_reg[1] ? accb_reg - tw : accb_reg + tw);
                        else
                            accw_reg <= (dstep_reg[1] ? accw_reg - tw : accw_reg + tw);
                        if (dstep_reg == 3'd7)
                            state_reg <= ST_WB;
                    end
                end
                ST_WB:
                begin
                    if (last_reg)
                    begin
                        out_reg <= elem_ok ? (stm ? arb_reg : arw_reg) : 16'd0;
                        last_reg <= 1'b0;
                        state_reg <= ST_OUT;
                    end
                    else if (32'(elem_reg) == HIDDEN_SIZE - 1)
                        state_reg <= ST_OUT;
                    else
                    begin
                        elem_reg <= elem_reg + ELEM_W'(1);
                        step_reg <= 3'd0;
                        step_v_reg <= 1'b1;
                        state_reg <= ST_RUN;
                    end
                end
                ST_OUT:
                begin
                    if (m_axis_tready)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WB) |-> !dv_reg)
        else $error("write-back with term in flight");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("accept while result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
endmodule
